// ===== src/laplacian_sharpen_3x3_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian sharpening unit
// Shared concurrent check forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_UNIT_MACROS_SVH
`define LAPLACIAN_SHARPEN_3X3_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define LAPSH_ASSERT_ALWAYS(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define LAPSH_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/lapsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lapsh_pkg
// Types and fixed constants shared by the Laplacian sharpening unit.
// ----------------------------------------------------------------------------
package lapsh_pkg;

  // configuration register widths and port width
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int GAIN_W       = 12;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  // gain is unsigned Q4.8
  localparam int GAIN_FRAC = 8;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [GAIN_W-1:0]       GAIN_RESET   = 12'd256;

  // result queue depth
  localparam int FIFO_DEPTH = 8;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SHARPEN_GAIN = 2'd2
  } reg_index_t;

  // per-result control carried down the pipeline
  typedef struct packed {
    logic drain;
    logic interior;
    logic last;
  } ctl_t;

endpackage

// ===== src/lapsh_ram.sv =====
// ----------------------------------------------------------------------------
// lapsh_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module lapsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read; a same-address read returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lapsh_sharpen.sv =====
// ----------------------------------------------------------------------------
// lapsh_sharpen
// Three-stage kernel datapath: Laplacian difference, gain multiply,
// rounding and clamping, with pass-through for border and drained pixels.
// ----------------------------------------------------------------------------
module lapsh_sharpen #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  lapsh_pkg::ctl_t                     in_ctl,
  input  logic [PIXEL_BITS-1:0]               in_drain_val,
  input  logic [8:0][PIXEL_BITS-1:0]          win,
  input  logic [lapsh_pkg::GAIN_W-1:0]        gain,
  output logic                                out_valid,
  output logic [PIXEL_BITS-1:0]               out_pixel,
  output logic                                out_last,
  output logic [1:0]                          busy
);

  localparam int SW = PIXEL_BITS + 3;                 // sum of 8 pixels
  localparam int DW = PIXEL_BITS + 4;                 // signed 8c - S
  localparam int PW = DW + lapsh_pkg::GAIN_W + 1;     // signed product
  localparam int VW = PW + 1;                         // product plus 256c
  localparam int QW = VW - lapsh_pkg::GAIN_FRAC;      // integer part
  localparam logic [QW:0] PIX_MAX = (QW + 1)'({PIXEL_BITS{1'b1}});

  // stage 2 registers (window is read live this cycle)
  logic                  s2_valid;
  lapsh_pkg::ctl_t       s2_ctl;
  logic [PIXEL_BITS-1:0] s2_drain_val;

  // stage 3 registers
  logic                  s3_valid;
  logic                  s3_interior;
  logic                  s3_last;
  logic [PIXEL_BITS-1:0] s3_pass;
  logic [PIXEL_BITS-1:0] s3_center;
  logic signed [DW-1:0]  s3_diff;

  // stage 4 registers
  logic                  s4_valid;
  logic                  s4_interior;
  logic                  s4_last;
  logic [PIXEL_BITS-1:0] s4_pass;
  logic [PIXEL_BITS-1:0] s4_center;
  logic signed [PW-1:0]  s4_prod;

  logic [SW-1:0]         nsum;
  logic signed [DW-1:0]  diff;
  logic signed [PW-1:0]  prod;
  logic signed [VW-1:0]  v;
  logic [QW:0]           rounded;
  logic [PIXEL_BITS-1:0] sharp;

  // neighbour sum and Laplacian difference
  always_comb begin
    nsum = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        nsum = nsum + SW'(win[i]);
      end
    end
    diff = $signed(DW'({win[4], 3'b000})) - $signed(DW'(nsum));
  end

  // gain multiply
  assign prod = PW'($signed({1'b0, gain})) * PW'(s3_diff);

  // v = 256c + k*d, then ceil(v/256) clamped to the pixel range
  always_comb begin
    v = ($signed(VW'(s4_center)) <<< lapsh_pkg::GAIN_FRAC) + VW'(s4_prod);
    rounded = (QW + 1)'(v[VW-1:lapsh_pkg::GAIN_FRAC])
            + (QW + 1)'(|v[lapsh_pkg::GAIN_FRAC-1:0]);
    if (v[VW-1]) begin
      sharp = '0;
    end else if (rounded > PIX_MAX) begin
      sharp = '1;
    end else begin
      sharp = rounded[PIXEL_BITS-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    s2_ctl       <= in_ctl;
    s2_drain_val <= in_drain_val;

    s3_interior  <= s2_ctl.interior && !s2_ctl.drain;
    s3_last      <= s2_ctl.last;
    s3_pass      <= s2_ctl.drain ? s2_drain_val : win[4];
    s3_center    <= win[4];
    s3_diff      <= diff;

    s4_interior  <= s3_interior;
    s4_last      <= s3_last;
    s4_pass      <= s3_pass;
    s4_center    <= s3_center;
    s4_prod      <= prod;
  end

  assign out_valid = s4_valid;
  assign out_pixel = s4_interior ? sharp : s4_pass;
  assign out_last  = s4_last;
  assign busy      = 2'({1'b0, s2_valid}) + 2'({1'b0, s3_valid}) + 2'({1'b0, s4_valid});

endmodule

// ===== src/lapsh_fifo.sv =====
// ----------------------------------------------------------------------------
// lapsh_fifo
// Small result queue in flip-flops; decouples the pipeline from the output.
// ----------------------------------------------------------------------------
module lapsh_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// ===== src/laplacian_sharpen_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_unit
// 3x3 Laplacian sharpening of a raster pixel stream. The unit accepts one
// item every clock cycle while input ready is high. A pixel or drain transfer
// reads both line stores at acceptance; the data returns in the next cycle,
// where the window shifts and the line stores are written back, with a bypass
// when the next access hits the same column. Three more stages compute the
// difference, the gain product and the clamped result, which then passes
// through the result queue to the output; the transfer that releases a pixel's
// result is the one a line plus one pixel after it. An 8-entry result queue
// holds results while the output stalls; input ready drops only in reset or
// when the queue plus the results in flight fill it. Border pixels pass through
// unchanged; drain transfers push out pending results at the end of a frame.
// Line stores need no clearing after reset: columns are written before they
// are read. Configure only while no results are outstanding.
// ----------------------------------------------------------------------------
`include "laplacian_sharpen_3x3_unit_macros.svh"

module laplacian_sharpen_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // input stream
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0]     s_axis_tdata,  // pixel_in
  input  logic                                        s_axis_tuser,  // drain
  // output stream
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0]     m_axis_tdata,  // pixel_out
  output logic                                        m_axis_tlast,  // last_of_frame
  // configuration writes
  input  logic                                        cfg_we,
  input  logic [lapsh_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  logic [lapsh_pkg::CFG_DATA_W-1:0]            cfg_wdata
);

  localparam int TW    = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 2);
  localparam int CMP_W = (WW > lapsh_pkg::WIDTH_REG_W) ? WW : lapsh_pkg::WIDTH_REG_W;
  localparam int ROW_W = lapsh_pkg::HEIGHT_REG_W;
  localparam int FC_W  = $clog2(lapsh_pkg::FIFO_DEPTH + 1);
  localparam int SUM_W = FC_W + 1;

  // configuration registers
  logic [lapsh_pkg::WIDTH_REG_W-1:0]  cfg_width;
  logic [lapsh_pkg::HEIGHT_REG_W-1:0] cfg_height;
  logic [lapsh_pkg::GAIN_W-1:0]       cfg_gain;
  logic [WW-1:0]                      eff_width;
  logic [ROW_W-1:0]                   eff_height;

  // position counters and pending count
  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic [WW-1:0]    pending, pending_next;

  // accept-side decode
  logic                  in_accept;
  logic                  drain;
  logic [PIXEL_BITS-1:0] pix;
  logic                  pend_gt_w;
  logic                  emit_now;
  logic                  in_col_wrap, in_row_wrap;
  logic                  out_col_wrap, out_row_wrap;
  logic [COL_W-1:0]      rd_addr;
  lapsh_pkg::ctl_t       acc_ctl;

  // read-data stage
  logic                  s1_valid;
  logic                  s1_emit;
  lapsh_pkg::ctl_t       s1_ctl;
  logic                  s1_sel_older;
  logic [COL_W-1:0]      s1_addr;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic                  s1_hit;
  logic [PIXEL_BITS-1:0] ram_older_q, ram_prev_q;
  logic [PIXEL_BITS-1:0] fwd_older, fwd_prev;
  logic [PIXEL_BITS-1:0] older_rd, prev_rd;
  logic [PIXEL_BITS-1:0] drain_val;
  logic                  s1_write;

  logic [8:0][PIXEL_BITS-1:0] win;

  // kernel and queue
  logic                  k_valid;
  logic [PIXEL_BITS-1:0] k_pixel;
  logic                  k_last;
  logic [1:0]            k_busy;
  logic [2:0]            inflight;
  logic [FC_W-1:0]       fifo_count;
  logic [PIXEL_BITS:0]   fifo_out;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= lapsh_pkg::WIDTH_RESET;
      cfg_height <= lapsh_pkg::HEIGHT_RESET;
      cfg_gain   <= lapsh_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lapsh_pkg::REG_IMAGE_WIDTH:  cfg_width  <= cfg_wdata[lapsh_pkg::WIDTH_REG_W-1:0];
        lapsh_pkg::REG_IMAGE_HEIGHT: cfg_height <= cfg_wdata[lapsh_pkg::HEIGHT_REG_W-1:0];
        lapsh_pkg::REG_SHARPEN_GAIN: cfg_gain   <= cfg_wdata[lapsh_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, width capped at the store depth
  always_comb begin
    if (cfg_width == '0) begin
      eff_width = WW'(1);
    end else if (CMP_W'(cfg_width) > CMP_W'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(cfg_width);
    end
    eff_height = (cfg_height == '0) ? ROW_W'(1) : cfg_height;
  end

  // accept-side decode
  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign drain        = s_axis_tuser;
  assign pix          = s_axis_tdata[PIXEL_BITS-1:0];
  assign pend_gt_w    = pending > eff_width;
  assign emit_now     = drain ? (pending != '0) : pend_gt_w;
  assign in_col_wrap  = (WW'(in_col) + WW'(1)) >= eff_width;
  assign in_row_wrap  = ((ROW_W + 1)'(in_row) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(eff_height);
  assign out_col_wrap = (WW'(out_col) + WW'(1)) >= eff_width;
  assign out_row_wrap = ((ROW_W + 1)'(out_row) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(eff_height);
  assign rd_addr      = drain ? out_col : in_col;

  always_comb begin
    acc_ctl.drain    = drain;
    acc_ctl.interior = (out_row != '0) && !out_row_wrap && (out_col != '0) && !out_col_wrap;
    acc_ctl.last     = out_col_wrap && out_row_wrap;
  end

  // counter next state
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    pending_next = pending;
    if (in_accept) begin
      if (!drain) begin
        in_col_next = in_col_wrap ? '0 : in_col + COL_W'(1);
        if (in_col_wrap) begin
          in_row_next = in_row_wrap ? '0 : in_row + ROW_W'(1);
        end
      end
      if (emit_now) begin
        out_col_next = out_col_wrap ? '0 : out_col + COL_W'(1);
        if (out_col_wrap) begin
          out_row_next = out_row_wrap ? '0 : out_row + ROW_W'(1);
        end
      end
      if (!drain && !emit_now) begin
        pending_next = pending + WW'(1);
      end else if (drain && emit_now) begin
        pending_next = pending - WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      pending  <= '0;
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      in_col   <= in_col_next;
      in_row   <= in_row_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      pending  <= pending_next;
      s1_valid <= in_accept;
      s1_emit  <= in_accept && emit_now;
    end
  end

  // read-data stage payload; hit flags a read of the column written now
  always_ff @(posedge clk) begin
    s1_ctl       <= acc_ctl;
    s1_sel_older <= pend_gt_w;
    s1_addr      <= rd_addr;
    s1_pix       <= pix;
    s1_hit       <= s1_valid && !s1_ctl.drain && (s1_addr == rd_addr);
  end

  // line stores
  lapsh_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram_older (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_addr),
    .wdata (prev_rd),
    .raddr (rd_addr),
    .rdata (ram_older_q)
  );

  lapsh_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram_prev (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_addr),
    .wdata (s1_pix),
    .raddr (rd_addr),
    .rdata (ram_prev_q)
  );

  // bypass of the write that raced the read
  assign s1_write  = s1_valid && !s1_ctl.drain;
  assign older_rd  = s1_hit ? fwd_older : ram_older_q;
  assign prev_rd   = s1_hit ? fwd_prev  : ram_prev_q;
  assign drain_val = s1_sel_older ? older_rd : prev_rd;

  always_ff @(posedge clk) begin
    if (s1_write) begin
      fwd_older <= prev_rd;
      fwd_prev  <= s1_pix;
    end
  end

  // 3x3 window, newest column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_write) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
      end
      win[2] <= older_rd;
      win[5] <= prev_rd;
      win[8] <= s1_pix;
    end
  end

  // kernel datapath
  lapsh_sharpen #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_sharpen (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s1_emit),
    .in_ctl       (s1_ctl),
    .in_drain_val (drain_val),
    .win          (win),
    .gain         (cfg_gain),
    .out_valid    (k_valid),
    .out_pixel    (k_pixel),
    .out_last     (k_last),
    .busy         (k_busy)
  );

  // result queue
  lapsh_fifo #(
    .WIDTH (PIXEL_BITS + 1),
    .DEPTH (lapsh_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (k_valid),
    .push_data ({k_last, k_pixel}),
    .pop_valid (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .pop_data  (fifo_out),
    .count     (fifo_count)
  );

  assign m_axis_tdata = TW'(fifo_out[PIXEL_BITS-1:0]);
  assign m_axis_tlast = fifo_out[PIXEL_BITS];

  // credit: take a transfer only if its result is sure of a queue slot
  assign inflight      = 3'({2'b00, s1_emit}) + 3'(k_busy);
  assign s_axis_tready = !rst
    && ((SUM_W'(fifo_count) + SUM_W'(inflight)) <= SUM_W'(lapsh_pkg::FIFO_DEPTH - 1));

  // checks
  `LAPSH_ASSERT_ALWAYS(a_credit_bound, clk, rst, (SUM_W'(fifo_count) + SUM_W'(inflight)) <= SUM_W'(lapsh_pkg::FIFO_DEPTH), "results in flight exceed queue room")
  `LAPSH_ASSERT_IMPLIES(a_push_room, clk, rst, k_valid, fifo_count != FC_W'(lapsh_pkg::FIFO_DEPTH), "result pushed into full queue")
  `LAPSH_ASSERT_IMPLIES(a_frame_wrap, clk, rst, s1_emit && s1_ctl.last, (out_col == '0) && (out_row == '0), "output position did not wrap after last pixel")

endmodule
